// File: sv/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared types and constants for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int TOL_BITS = 8;

	typedef enum logic [1:0] {
		ORI_ZERO,
		ORI_POS,
		ORI_NEG
	} orient_t;

endpackage

// File: sv/sit_orient.sv
// ----------------------------------------------------------------------------
// Orientation sign pipeline
// Three-stage sign of the exact cross product of a point about a segment:
// differences, products, then subtraction and sign.
// ----------------------------------------------------------------------------
module sit_orient #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  logic signed [COORD_BITS-1:0] sx,
	input  logic signed [COORD_BITS-1:0] sy,
	input  logic signed [COORD_BITS-1:0] ex,
	input  logic signed [COORD_BITS-1:0] ey,
	output sit_pkg::orient_t             ori
);
	import sit_pkg::*;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUB_W  = PROD_W + 1;

	logic signed [DIFF_W-1:0] ux_s1, uy_s1, vx_s1, vy_s1;
	logic signed [PROD_W-1:0] p_s2, q_s2;
	logic signed [SUB_W-1:0]  cross_prod;
	orient_t                  ori_s3;

	assign cross_prod = SUB_W'(p_s2) - SUB_W'(q_s2);

	always_ff @(posedge clk) begin
		ux_s1 <= DIFF_W'(ex) - DIFF_W'(sx);
		uy_s1 <= DIFF_W'(ey) - DIFF_W'(sy);
		vx_s1 <= DIFF_W'(px) - DIFF_W'(sx);
		vy_s1 <= DIFF_W'(py) - DIFF_W'(sy);
		p_s2  <= ux_s1 * vy_s1;
		q_s2  <= uy_s1 * vx_s1;
		if (cross_prod == '0) begin
			ori_s3 <= ORI_ZERO;
		end else if (cross_prod[SUB_W-1]) begin
			ori_s3 <= ORI_NEG;
		end else begin
			ori_s3 <= ORI_POS;
		end
	end

	assign ori = ori_s3;

endmodule

// File: sv/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// Segment intersection test
// Decides per request whether two 2-D segments cross or touch, using exact
// orientation signs and a widened bounding-box check for collinear cases.
// ----------------------------------------------------------------------------
// Channel   Ports                                  Handshake
// request   start, busy, first_*, second_*         taken when start && !busy
// config    cfg_wr_en, cfg_wr_data                 written when cfg_wr_en
// result    done, segments_meet                    one-cycle strobe on done
//
// One request is taken every cycle; busy is never raised.
// The result passes through the three-stage orientation pipeline
// (differences, products, sign) and then through the output register.
// Reset clears the valid bits and the tolerance register to zero.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  first_start_x,
	input  logic signed [COORD_BITS-1:0]  first_start_y,
	input  logic signed [COORD_BITS-1:0]  first_end_x,
	input  logic signed [COORD_BITS-1:0]  first_end_y,
	input  logic signed [COORD_BITS-1:0]  second_start_x,
	input  logic signed [COORD_BITS-1:0]  second_start_y,
	input  logic signed [COORD_BITS-1:0]  second_end_x,
	input  logic signed [COORD_BITS-1:0]  second_end_y,
	input  logic                          cfg_wr_en,
	input  logic [sit_pkg::TOL_BITS-1:0]  cfg_wr_data,
	output logic                          done,
	output logic                          segments_meet
);
	import sit_pkg::*;

	localparam int BOX_W = ((COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS) + 2;

	logic [TOL_BITS-1:0]             tol_q;
	logic                            v_s1, v_s2, v_s3;
	logic                            done_q, meet_q;

	logic signed [COORD_BITS-1:0]    px_s1 [4];
	logic signed [COORD_BITS-1:0]    py_s1 [4];
	logic signed [COORD_BITS-1:0]    minx_s1 [2];
	logic signed [COORD_BITS-1:0]    maxx_s1 [2];
	logic signed [COORD_BITS-1:0]    miny_s1 [2];
	logic signed [COORD_BITS-1:0]    maxy_s1 [2];
	logic [3:0]                      in_box;
	logic [3:0]                      in_box_s2, in_box_s3;
	logic signed [BOX_W-1:0]         tol_ext;

	orient_t                         o1, o2, o3, o4;
	logic                            a_zero, b_zero, a_pos, b_pos, meet;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
			meet_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
			meet_q <= v_s3 && meet;
		end
	end

	// Points 0 and 1 are tested against the first box, points 2 and 3 against
	// the second box.
	always_ff @(posedge clk) begin
		px_s1[0] <= second_start_x;
		py_s1[0] <= second_start_y;
		px_s1[1] <= second_end_x;
		py_s1[1] <= second_end_y;
		px_s1[2] <= first_start_x;
		py_s1[2] <= first_start_y;
		px_s1[3] <= first_end_x;
		py_s1[3] <= first_end_y;
		minx_s1[0] <= (first_start_x < first_end_x) ? first_start_x : first_end_x;
		maxx_s1[0] <= (first_start_x < first_end_x) ? first_end_x : first_start_x;
		miny_s1[0] <= (first_start_y < first_end_y) ? first_start_y : first_end_y;
		maxy_s1[0] <= (first_start_y < first_end_y) ? first_end_y : first_start_y;
		minx_s1[1] <= (second_start_x < second_end_x) ? second_start_x : second_end_x;
		maxx_s1[1] <= (second_start_x < second_end_x) ? second_end_x : second_start_x;
		miny_s1[1] <= (second_start_y < second_end_y) ? second_start_y : second_end_y;
		maxy_s1[1] <= (second_start_y < second_end_y) ? second_end_y : second_start_y;
		in_box_s2  <= in_box;
		in_box_s3  <= in_box_s2;
	end

	assign tol_ext = $signed(BOX_W'(tol_q));

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			in_box[i] =
				(BOX_W'(px_s1[i]) >= BOX_W'(minx_s1[i/2]) - tol_ext) &&
				(BOX_W'(px_s1[i]) <= BOX_W'(maxx_s1[i/2]) + tol_ext) &&
				(BOX_W'(py_s1[i]) >= BOX_W'(miny_s1[i/2]) - tol_ext) &&
				(BOX_W'(py_s1[i]) <= BOX_W'(maxy_s1[i/2]) + tol_ext);
		end
	end

	sit_orient #(.COORD_BITS(COORD_BITS)) u_ori_c (
		.clk(clk),
		.px(second_start_x), .py(second_start_y),
		.sx(first_start_x),  .sy(first_start_y),
		.ex(first_end_x),    .ey(first_end_y),
		.ori(o1)
	);

	sit_orient #(.COORD_BITS(COORD_BITS)) u_ori_d (
		.clk(clk),
		.px(second_end_x),   .py(second_end_y),
		.sx(first_start_x),  .sy(first_start_y),
		.ex(first_end_x),    .ey(first_end_y),
		.ori(o2)
	);

	sit_orient #(.COORD_BITS(COORD_BITS)) u_ori_a (
		.clk(clk),
		.px(first_start_x),  .py(first_start_y),
		.sx(second_start_x), .sy(second_start_y),
		.ex(second_end_x),   .ey(second_end_y),
		.ori(o3)
	);

	sit_orient #(.COORD_BITS(COORD_BITS)) u_ori_b (
		.clk(clk),
		.px(first_end_x),    .py(first_end_y),
		.sx(second_start_x), .sy(second_start_y),
		.ex(second_end_x),   .ey(second_end_y),
		.ori(o4)
	);

	always_comb begin
		a_zero = (o1 == ORI_ZERO) || (o2 == ORI_ZERO);
		b_zero = (o3 == ORI_ZERO) || (o4 == ORI_ZERO);
		a_pos  = ((o1 == ORI_POS) && (o2 == ORI_POS)) || ((o1 == ORI_NEG) && (o2 == ORI_NEG));
		b_pos  = ((o3 == ORI_POS) && (o4 == ORI_POS)) || ((o3 == ORI_NEG) && (o4 == ORI_NEG));
		if (a_zero && b_zero) begin
			meet = ((o1 == ORI_ZERO) && in_box_s3[0]) ||
				((o2 == ORI_ZERO) && in_box_s3[1]) ||
				((o3 == ORI_ZERO) && in_box_s3[2]) ||
				((o4 == ORI_ZERO) && in_box_s3[3]);
		end else begin
			meet = !a_pos && !b_pos;
		end
	end

	assign done          = done_q;
	assign segments_meet = meet_q;

`ifndef NO_ASSERTIONS
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("request did not produce a result after four cycles");

	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without a matching request");

	a_meet_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !segments_meet)
		else $error("segments_meet raised without a result strobe");

	a_cross_meets: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !a_zero && !b_zero && !a_pos && !b_pos |=> segments_meet)
		else $error("proper crossing was not reported as meeting");
`endif

endmodule
